// File: rtl/fixed_block_pool_allocator_assert.svh
// Assertion macros for the allocator checker.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// clocked check, off while reset is high
`define FBPA_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds through reset
`define FBPA_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/fbpa_pkg.sv
// Types and codes shared by the block pool allocator and its checker.
// No dependencies.
`timescale 1ns / 1ps

package fbpa_pkg;

   localparam int OFFSET_W     = 32;
   localparam int RSP_INDEX_W  = 6;
   localparam int RSP_OFFSET_W = 11;

   typedef logic                    req_kind_type;
   typedef logic signed [OFFSET_W-1:0] offset_type;
   typedef logic [RSP_INDEX_W-1:0]  rsp_index_type;
   typedef logic [RSP_OFFSET_W-1:0] rsp_offset_type;

   localparam req_kind_type REQ_ALLOC = 1'b0;
   localparam req_kind_type REQ_FREE  = 1'b1;

endpackage

// File: rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator: LIFO free list in a link memory plus an
// allocated-bit memory. Depends on fbpa_pkg.
//
//   channel   ports                               transfer when
//   request   req_type, req_byte_offset           start && !busy
//   result    rsp_success, rsp_slot_index,        rsp_strobe (one cycle)
//             rsp_block_byte_offset
//
// Allocate: the ALLOC state, bound by the registered read of the head's next link.
// Free: reciprocal multiply, back-multiply, remainder fix-up, then the
// allocated-bit read and write-back.
// No clearing pass at reset: a fill count marks the blocks never handed out,
// whose links and bits are not used.
// One request at a time; results cannot be stalled.
`timescale 1ns / 1ps

module fixed_block_pool_allocator #(
   parameter int BLOCK_COUNT = 64,
   parameter int BLOCK_BYTES = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  fbpa_pkg::req_kind_type  req_type,
   input  fbpa_pkg::offset_type    req_byte_offset,
   output logic                    rsp_strobe,
   output logic                    rsp_success,
   output fbpa_pkg::rsp_index_type  rsp_slot_index,
   output fbpa_pkg::rsp_offset_type rsp_block_byte_offset
);
   import fbpa_pkg::*;

   localparam int IDX_W  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam int LINK_W = $clog2(BLOCK_COUNT + 1);
   localparam int RCP_W  = 30;
   localparam logic [63:0] RECIP64 = (64'd1 << 31) / BLOCK_BYTES;
   localparam logic [63:0] POOL64  = 64'(BLOCK_COUNT) * 64'(BLOCK_BYTES);
   localparam logic [LINK_W-1:0] LIST_END = LINK_W'(BLOCK_COUNT);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ALLOC = 3'd1;
   localparam logic [2:0] ST_MUL1  = 3'd2;
   localparam logic [2:0] ST_MUL2  = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_FREE  = 3'd5;

   // memories
   logic [LINK_W-1:0] link_mem [BLOCK_COUNT];
   logic              bit_mem  [BLOCK_COUNT];

   logic [2:0]        state_ff, state_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] fresh_ff, fresh_in;
   logic [30:0]       off_ff, off_in;
   logic              range_ff, range_in;
   logic [RCP_W-1:0]  q0_ff, q0_in;
   logic [31:0]       back_ff, back_in;
   logic [IDX_W-1:0]  blk_ff, blk_in;
   logic              okfree_ff, okfree_in;
   logic [LINK_W-1:0] link_rd_ff;
   logic              bit_rd_ff;

   logic              strobe_ff, strobe_in;
   logic              success_ff, success_in;
   rsp_index_type     index_ff, index_in;
   rsp_offset_type    boff_ff, boff_in;

   logic              accept;
   logic [IDX_W-1:0]  head_idx;
   logic [60:0]       prod;
   logic [46:0]       backp;
   logic [31:0]       rem, rem_fix;
   logic [RCP_W-1:0]  q_fix;
   logic [31:0]       boff_full;
   logic              link_we;
   logic              bit_we, bit_wd;
   logic [IDX_W-1:0]  bit_wa;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign head_idx = head_ff[IDX_W-1:0];

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      fresh_in   = fresh_ff;
      off_in     = off_ff;
      range_in   = range_ff;
      q0_in      = q0_ff;
      back_in    = back_ff;
      blk_in     = blk_ff;
      okfree_in  = okfree_ff;
      strobe_in  = 1'b0;
      success_in = 1'b0;
      index_in   = '0;
      boff_in    = '0;
      link_we    = 1'b0;
      bit_we     = 1'b0;
      bit_wa     = head_idx;
      bit_wd     = 1'b0;
      prod       = 61'(off_ff) * 61'(RECIP64[RCP_W-1:0]);
      backp      = 47'(q0_ff) * 47'(BLOCK_BYTES);
      rem        = {1'b0, off_ff} - back_ff;
      q_fix      = q0_ff;
      rem_fix    = rem;
      // truncated reciprocal undershoots the quotient by at most one
      if (rem >= 32'(BLOCK_BYTES)) begin
         q_fix   = q0_ff + RCP_W'(1);
         rem_fix = rem - 32'(BLOCK_BYTES);
      end
      boff_full  = 32'(head_idx) * 32'(BLOCK_BYTES);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               off_in   = req_byte_offset[30:0];
               range_in = !req_byte_offset[31] &&
                          ({2'b00, req_byte_offset[30:0]} < POOL64[32:0]);
               state_in = (req_type == REQ_ALLOC) ? ST_ALLOC : ST_MUL1;
            end
         end
         ST_ALLOC: begin
            strobe_in = 1'b1;
            if (head_ff != LIST_END) begin
               success_in = 1'b1;
               index_in   = RSP_INDEX_W'(32'(head_idx));
               boff_in    = boff_full[RSP_OFFSET_W-1:0];
               bit_we     = 1'b1;
               bit_wa     = head_idx;
               bit_wd     = 1'b1;
               // past the fill count the list still runs in index order
               if (head_ff >= fresh_ff) begin
                  head_in  = head_ff + LINK_W'(1);
                  fresh_in = head_ff + LINK_W'(1);
               end else begin
                  head_in = link_rd_ff;
               end
            end
            state_in = ST_IDLE;
         end
         ST_MUL1: begin
            q0_in    = prod[60:31];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            back_in  = backp[31:0];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            blk_in    = q_fix[IDX_W-1:0];
            okfree_in = range_ff && (rem_fix == 32'd0) &&
                        (32'(q_fix) < 32'(fresh_ff));
            state_in  = ST_FREE;
         end
         ST_FREE: begin
            strobe_in = 1'b1;
            if (okfree_ff && bit_rd_ff) begin
               success_in = 1'b1;
               bit_we     = 1'b1;
               bit_wa     = blk_ff;
               bit_wd     = 1'b0;
               link_we    = 1'b1;
               head_in    = LINK_W'(blk_ff);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         fresh_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         fresh_ff  <= fresh_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff     <= off_in;
      range_ff   <= range_in;
      q0_ff      <= q0_in;
      back_ff    <= back_in;
      blk_ff     <= blk_in;
      okfree_ff  <= okfree_in;
      success_ff <= success_in;
      index_ff   <= index_in;
      boff_ff    <= boff_in;
   end

   // link memory: read the head's next link at the transfer edge
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[blk_ff] <= head_ff;
      end
      if (accept) begin
         link_rd_ff <= link_mem[head_idx];
      end
   end

   // allocated-bit memory
   always_ff @(posedge clock) begin
      if (bit_we) begin
         bit_mem[bit_wa] <= bit_wd;
      end
      if (state_ff == ST_CHECK) begin
         bit_rd_ff <= bit_mem[q_fix[IDX_W-1:0]];
      end
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_success           = success_ff;
   assign rsp_slot_index        = index_ff;
   assign rsp_block_byte_offset = boff_ff;

endmodule

// File: rtl/fbpa_checker.sv
// Port-level checks for the block pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_assert.svh.
`timescale 1ns / 1ps
`include "fixed_block_pool_allocator_assert.svh"

module fbpa_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input fbpa_pkg::req_kind_type   req_type,
   input logic                     rsp_strobe,
   input logic                     rsp_success,
   input fbpa_pkg::rsp_index_type  rsp_slot_index,
   input fbpa_pkg::rsp_offset_type rsp_block_byte_offset
);
   import fbpa_pkg::*;

   `FBPA_CHECK(a_accept_busy, (start && !busy) |=> busy, "no busy after transfer")
   `FBPA_CHECK(a_alloc_two,
      (start && !busy && req_type == REQ_ALLOC) |=> ##1 rsp_strobe, "allocate result late")
   `FBPA_CHECK(a_rsp_idle, rsp_strobe |-> (!busy && $past(busy)), "result outside request")
   `FBPA_CHECK(a_fail_zero,
      (rsp_strobe && !rsp_success) |->
         (rsp_slot_index == '0 && rsp_block_byte_offset == '0),
      "failed result not zero")
   `FBPA_CHECK_ALWAYS(a_reset_quiet, reset |=> (!busy && !rsp_strobe), "activity after reset")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .req_type              (req_type),
   .rsp_strobe            (rsp_strobe),
   .rsp_success           (rsp_success),
   .rsp_slot_index        (rsp_slot_index),
   .rsp_block_byte_offset (rsp_block_byte_offset)
);

// File: verif/fixed_block_pool_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for fixed_block_pool_allocator: directed and random allocate/free
// transfers checked against a free-list model kept in the bench.
// Depends on fbpa_pkg and the allocator RTL.

module fixed_block_pool_allocator_tb;
   import fbpa_pkg::*;

   localparam int BLOCK_COUNT   = 64;
   localparam int BLOCK_BYTES   = 32;
   localparam int POOL_BYTES    = BLOCK_COUNT * BLOCK_BYTES;
   localparam int RANDOM_REQS   = 1750;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct {
      req_kind_type kind;
      offset_type   offset;
   } pool_req_type;

   typedef struct {
      logic           success;
      rsp_index_type  index;
      rsp_offset_type byte_off;
   } pool_rsp_type;

   logic           clock           = 1'b0;
   logic           reset           = 1'b1;
   logic           start           = 1'b0;
   req_kind_type   req_type        = REQ_ALLOC;
   offset_type     req_byte_offset = '0;
   logic           busy;
   logic           rsp_strobe;
   logic           rsp_success;
   rsp_index_type  rsp_slot_index;
   rsp_offset_type rsp_block_byte_offset;

   // free-list model: head, next links, allocated bits
   int unsigned model_head;
   int unsigned model_next [BLOCK_COUNT];
   bit          model_taken [BLOCK_COUNT];

   pool_req_type pending_reqs [$];
   pool_rsp_type expected_rsps [$];
   pool_req_type cur_req;
   bit          req_in_hand   = 1'b0;
   bit          mismatch_seen = 1'b0;
   int unsigned gap_left      = 0;
   int unsigned burst_left    = 0;
   int unsigned cycle_count   = 0;

   fixed_block_pool_allocator #(
      .BLOCK_COUNT(BLOCK_COUNT),
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_byte_offset      (req_byte_offset),
      .rsp_strobe           (rsp_strobe),
      .rsp_success          (rsp_success),
      .rsp_slot_index       (rsp_slot_index),
      .rsp_block_byte_offset(rsp_block_byte_offset)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one request to the model and returns the result it must produce.
   function automatic pool_rsp_type predict_pool(pool_req_type r);
      pool_rsp_type res;
      logic [31:0] raw;
      int unsigned blk;
      res.success  = 1'b0;
      res.index    = '0;
      res.byte_off = '0;
      raw = r.offset;
      if (r.kind == REQ_ALLOC) begin
         if (model_head < BLOCK_COUNT) begin
            blk = model_head;
            model_head = model_next[blk];
            model_taken[blk] = 1'b1;
            res.success  = 1'b1;
            res.index    = rsp_index_type'(blk);
            res.byte_off = rsp_offset_type'(blk * BLOCK_BYTES);
         end
      end else if (!raw[31] && raw < POOL_BYTES && raw % BLOCK_BYTES == 0) begin
         blk = raw / BLOCK_BYTES;
         if (model_taken[blk]) begin
            model_taken[blk] = 1'b0;
            model_next[blk] = model_head;
            model_head = blk;
            res.success = 1'b1;
         end
      end
      return res;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a run of back-to-back transfers.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Mostly offsets of blocks the model holds as allocated; the rest are random block offsets and the failing kinds.
   function automatic offset_type pick_free_offset();
      int unsigned r;
      int unsigned base;
      int unsigned idx;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         base = $urandom_range(0, BLOCK_COUNT - 1);
         for (int k = 0; k < BLOCK_COUNT; k++) begin
            idx = (base + k) % BLOCK_COUNT;
            if (model_taken[idx]) return offset_type'(idx * BLOCK_BYTES);
         end
         return offset_type'(base * BLOCK_BYTES);
      end
      if (r < 80) return offset_type'($urandom_range(0, BLOCK_COUNT - 1) * BLOCK_BYTES);
      if (r < 85) begin
         return offset_type'($urandom_range(0, BLOCK_COUNT - 1) * BLOCK_BYTES
                             + $urandom_range(1, BLOCK_BYTES - 1));
      end
      if (r < 90) return offset_type'($urandom_range(POOL_BYTES, 32'h7FFF_FFFF));
      if (r < 95) return offset_type'({1'b1, 31'($urandom)});
      return offset_type'($urandom);
   endfunction

   task automatic queue_req(req_kind_type kind, offset_type offset);
      pool_req_type r;
      r.kind   = kind;
      r.offset = offset;
      pending_reqs.push_back(r);
   endtask

   // Request driver: a transfer happens on start && !busy; start is set once per edge.
   always @(posedge clock) begin : drive_requests
      logic next_start;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            expected_rsps.push_back(predict_pool(cur_req));
            req_in_hand = 1'b0;
            next_start  = 1'b0;
            gap_left    = pick_gap();
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
               // junk on the fields while idle; must be ignored
               req_type        <= req_kind_type'($urandom_range(0, 1));
               req_byte_offset <= offset_type'($urandom);
            end else if (pending_reqs.size() > 0) begin
               cur_req         = pending_reqs.pop_front();
               req_in_hand     = 1'b1;
               req_type        <= cur_req.kind;
               req_byte_offset <= cur_req.offset;
               next_start      = 1'b1;
            end
         end
         start <= next_start;
      end
   end

   // Result monitor: results cannot be stalled, so every strobe is a transfer.
   always @(posedge clock) begin : check_results
      pool_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: result with none expected: expected none, actual %0b/%0d/%0d",
                     $time, rsp_success, rsp_slot_index, rsp_block_byte_offset);
            mismatch_seen = 1'b1;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_success !== want.success) begin
               $display("%0t: success: expected %0b actual %0b",
                        $time, want.success, rsp_success);
               mismatch_seen = 1'b1;
            end
            if (rsp_slot_index !== want.index) begin
               $display("%0t: slot_index: expected %0d actual %0d",
                        $time, want.index, rsp_slot_index);
               mismatch_seen = 1'b1;
            end
            if (rsp_block_byte_offset !== want.byte_off) begin
               $display("%0t: block_byte_offset: expected %0d actual %0d",
                        $time, want.byte_off, rsp_block_byte_offset);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned phase_left;
      int unsigned alloc_pct;
      phase_left = 0;
      alloc_pct  = 50;
      model_head = 0;
      for (int i = 0; i < BLOCK_COUNT; i++) begin
         model_next[i]  = i + 1;
         model_taken[i] = 1'b0;
      end

      // directed: free before any allocate, double free, bad offsets, LIFO reuse
      queue_req(REQ_FREE,  32'sd0);
      queue_req(REQ_ALLOC, 32'sd0);
      queue_req(REQ_ALLOC, 32'sd0);
      queue_req(REQ_ALLOC, 32'sd0);
      queue_req(REQ_FREE,  32'sd32);
      queue_req(REQ_FREE,  32'sd32);
      queue_req(REQ_FREE,  -32'sd32);
      queue_req(REQ_FREE,  offset_type'(32'h8000_0000));
      queue_req(REQ_FREE,  offset_type'(32'h7FFF_FFFF));
      queue_req(REQ_FREE,  offset_type'(POOL_BYTES));
      queue_req(REQ_FREE,  offset_type'(POOL_BYTES - 1));
      queue_req(REQ_FREE,  32'sd33);
      queue_req(REQ_FREE,  offset_type'(32'hFFFF_FFFF));
      queue_req(REQ_ALLOC, offset_type'(32'hFFFF_FFFF));
      queue_req(REQ_FREE,  offset_type'(POOL_BYTES - BLOCK_BYTES));
      queue_req(REQ_FREE,  32'sd0);
      queue_req(REQ_FREE,  32'sd64);
      queue_req(REQ_ALLOC, 32'sd0);
      queue_req(REQ_ALLOC, 32'sd0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // random phases: alloc-heavy runs drain the list to empty, free-heavy runs refill it
      for (int n = 0; n < RANDOM_REQS; n++) begin
         while (pending_reqs.size() >= 2) @(posedge clock);
         if (phase_left == 0) begin
            phase_left = $urandom_range(60, 140);
            case ($urandom_range(0, 2))
               0: alloc_pct = 85;
               1: alloc_pct = 20;
               default: alloc_pct = 50;
            endcase
         end
         phase_left--;
         if ($urandom_range(1, 100) <= alloc_pct) begin
            queue_req(REQ_ALLOC, offset_type'($urandom));
         end else begin
            queue_req(REQ_FREE, pick_free_offset());
         end
      end

      while (pending_reqs.size() > 0 || req_in_hand) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_seen) begin
         $display("SCOREBOARD MISMATCH");
      end else begin
         $display("SCOREBOARD CLEAN");
      end
      $finish;
   end

endmodule
